// ===== hw/rtl/oaht_pkg.sv =====
package oaht_pkg;

	// table geometry
	localparam int TABLE_SIZE = 13;
	localparam int KEY_BITS   = 16;

	localparam int SLOT_W = $clog2(TABLE_SIZE);
	localparam int CNT_W  = $clog2(TABLE_SIZE);
	localparam int PRB_W  = $clog2(TABLE_SIZE + 1);

	// result field widths
	localparam int SLOT_IDX_W = 4;
	localparam int STATUS_W   = 2;
	localparam int PROBES_W   = 4;

	// config port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_PROBE_MODE = 1'b0;   // register index, paddr[2]

	// key mod TABLE_SIZE by reciprocal: q estimate is q or q-1
	localparam int RED_SH = KEY_BITS + $clog2(TABLE_SIZE);
	localparam int M_W    = KEY_BITS + 1;
	localparam int PROD_W = KEY_BITS + M_W;
	localparam logic [63:0] RED_M = (64'd1 << RED_SH) / 64'(TABLE_SIZE);

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_FIND   = 1'b1;

	localparam logic MODE_LINEAR = 1'b0;
	localparam logic MODE_QUAD   = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_ZERO_KEY  = 2'd3
	} status_t;

	typedef struct packed {
		logic accept;   // take the input transaction
		logic reduce;   // key mod size -> first slot
		logic probe;    // examine one slot
		logic emit;     // load output register
	} oaht_cmd_t;

	typedef struct packed {
		logic key_zero;
		logic hit;
		logic last;
	} oaht_stat_t;

endpackage

// ===== hw/rtl/oaht_ctrl.sv =====
module oaht_ctrl
	import oaht_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  oaht_stat_t stat,
	output oaht_cmd_t  cmd
);

	typedef enum logic [1:0] {
		IDLE,
		REDUCE,
		PROBE,
		FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == IDLE) && in_valid;
		cmd.reduce = (state_q == REDUCE);
		cmd.probe  = (state_q == PROBE);
		cmd.emit   = (state_q == FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (in_valid)
						state_q <= stat.key_zero ? FINISH : REDUCE;
				end
				REDUCE: begin
					state_q <= PROBE;
				end
				PROBE: begin
					if (stat.hit || stat.last)
						state_q <= FINISH;
				end
				FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_rise_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == FINISH))
		else $error("result raised outside FINISH");

	a_probe_follows_reduce: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cmd.probe) |-> $past(cmd.reduce))
		else $error("probe loop entered without reduction");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.reduce, cmd.probe, cmd.emit}))
		else $error("more than one datapath command");
`endif

endmodule

// ===== hw/rtl/oaht_dp.sv =====
module oaht_dp
	import oaht_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  oaht_cmd_t             cmd,
	output oaht_stat_t            stat,
	input  logic                  probe_mode,
	input  logic                  req_type,
	input  logic [KEY_BITS-1:0]   search_key,
	output logic [SLOT_IDX_W-1:0] slot_index,
	output logic [STATUS_W-1:0]   status,
	output logic [PROBES_W-1:0]   probes_used
);

	localparam int RW = SLOT_W + 1;

	logic [KEY_BITS-1:0] store_q [TABLE_SIZE];

	logic [KEY_BITS-1:0] key_q;
	logic                req_q;
	logic [PROD_W-1:0]   prod_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   step_q;
	logic [CNT_W-1:0]    idx_q;

	logic [SLOT_W-1:0]   res_slot_q;
	status_t             res_status_q;
	logic [PRB_W-1:0]    res_probes_q;

	logic [SLOT_W-1:0]   out_slot_q;
	status_t             out_status_q;
	logic [PRB_W-1:0]    out_probes_q;

	logic [KEY_BITS-1:0] quo;
	logic [RW-1:0]       rem_raw;
	logic [RW-1:0]       rem_fix;
	logic [KEY_BITS-1:0] rd_key;
	logic [RW-1:0]       lin_sum;
	logic [RW-1:0]       quad_sum;
	logic [RW-1:0]       step_sum;
	logic [SLOT_W-1:0]   slot_nxt;
	logic [SLOT_W-1:0]   step_nxt;
	logic [PRB_W-1:0]    probes_now;

	// remainder: key - q_est*T lies below 2T
	assign quo     = KEY_BITS'(prod_q >> RED_SH);
	assign rem_raw = RW'(key_q) - RW'(quo * KEY_BITS'(TABLE_SIZE));
	assign rem_fix = (rem_raw >= RW'(TABLE_SIZE)) ? rem_raw - RW'(TABLE_SIZE) : rem_raw;

	assign rd_key = store_q[slot_q];

	// linear: +1; quadratic: +(2i+1), carried as step_q mod T
	assign lin_sum  = RW'(slot_q) + RW'(1);
	assign quad_sum = RW'(slot_q) + RW'(step_q);
	assign step_sum = RW'(step_q) + RW'(2);

	always_comb begin
		if (probe_mode == MODE_QUAD)
			slot_nxt = SLOT_W'((quad_sum >= RW'(TABLE_SIZE)) ?
				quad_sum - RW'(TABLE_SIZE) : quad_sum);
		else
			slot_nxt = SLOT_W'((lin_sum >= RW'(TABLE_SIZE)) ?
				lin_sum - RW'(TABLE_SIZE) : lin_sum);
		step_nxt = SLOT_W'((step_sum >= RW'(TABLE_SIZE)) ?
			step_sum - RW'(TABLE_SIZE) : step_sum);
	end

	assign probes_now = PRB_W'(idx_q) + PRB_W'(1);

	assign stat.key_zero = (search_key == '0);
	assign stat.hit      = (req_q == REQ_FIND) ? (rd_key == key_q) : (rd_key == '0);
	assign stat.last     = (idx_q == CNT_W'(TABLE_SIZE - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TABLE_SIZE; k++)
				store_q[k] <= '0;
		end else if (cmd.probe && stat.hit && (req_q == REQ_INSERT)) begin
			store_q[slot_q] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q  <= search_key;
			req_q  <= req_type;
			prod_q <= PROD_W'(search_key) * PROD_W'(RED_M);
			if (stat.key_zero) begin
				res_slot_q   <= '0;
				res_status_q <= ST_ZERO_KEY;
				res_probes_q <= '0;
			end
		end
		if (cmd.reduce) begin
			slot_q <= SLOT_W'(rem_fix);
			step_q <= SLOT_W'(1);
			idx_q  <= '0;
		end
		if (cmd.probe) begin
			if (stat.hit) begin
				res_slot_q   <= slot_q;
				res_status_q <= ST_OK;
				res_probes_q <= probes_now;
			end else if (stat.last) begin
				res_slot_q   <= '0;
				res_status_q <= (req_q == REQ_FIND) ? ST_NOT_FOUND : ST_FULL;
				res_probes_q <= probes_now;
			end else begin
				slot_q <= slot_nxt;
				step_q <= step_nxt;
				idx_q  <= idx_q + CNT_W'(1);
			end
		end
		if (cmd.emit) begin
			out_slot_q   <= res_slot_q;
			out_status_q <= res_status_q;
			out_probes_q <= res_probes_q;
		end
	end

	assign slot_index  = SLOT_IDX_W'(out_slot_q);
	assign status      = out_status_q;
	assign probes_used = PROBES_W'(out_probes_q);

`ifndef SYNTHESIS
	a_base_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.reduce) |-> (slot_q < SLOT_W'(TABLE_SIZE)))
		else $error("first slot out of range");

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe |-> (slot_q < SLOT_W'(TABLE_SIZE)) && (step_q < SLOT_W'(TABLE_SIZE)))
		else $error("probe slot or step out of range");

	a_write_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.probe && stat.hit && (req_q == REQ_INSERT)) |=> (store_q[$past(slot_q)] == $past(key_q)))
		else $error("insert did not land");
`endif

endmodule

// ===== hw/rtl/open_addressing_hash_table.sv =====
// Open-addressing hash table of 13 nonzero 16-bit keys, cleared at reset.
// Each input transaction is an insert (req_type 0) or a find (req_type 1);
// each gives one result transaction carrying slot_index, status (0 ok,
// 1 not found, 2 full, 3 zero key) and probes_used. Probing is linear,
// (key+i) mod 13, or quadratic, (key+i*i) mod 13, chosen by the probe_mode
// register at APB byte address 0 (bit 0; reads back, resets to linear).
// Write probe_mode only while the block is idle. Finds probe past empty
// slots, so a miss always costs all 13 probes; inserts do not check for
// duplicates. One item at a time: in_stall is high from the cycle after
// acceptance until the result is loaded into the output register. While
// stalled, a request forms key mod 13 via a reciprocal multiply (REDUCE),
// runs the probe loop (PROBE, one slot read and compare per cycle) and
// loads the output (FINISH); a zero key goes straight to FINISH. A new
// request may be accepted while the previous result still waits on
// out_stall.
module open_addressing_hash_table
	import oaht_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// APB config port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic [KEY_BITS-1:0]   search_key,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SLOT_IDX_W-1:0] slot_index,
	output logic [STATUS_W-1:0]   status,
	output logic [PROBES_W-1:0]   probes_used
);

	oaht_cmd_t  cmd;
	oaht_stat_t stat;
	logic       probe_mode_q;
	logic       reg_sel;

	// register index is the word address; byte offset bits ignored
	assign reg_sel = (paddr[PADDR_W-1] == REG_PROBE_MODE);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? PDATA_W'(probe_mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_mode_q <= MODE_LINEAR;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			probe_mode_q <= pwdata[0];
		end
	end

	oaht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	oaht_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.probe_mode  (probe_mode_q),
		.req_type    (req_type),
		.search_key  (search_key),
		.slot_index  (slot_index),
		.status      (status),
		.probes_used (probes_used)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import oaht_pkg::*;

	// run length guard: worst case is ~1100 transactions, stretched by 47% gaps
	// and stalls plus the long hold, many times over
	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 135;
	localparam int RANDOM_PHASES = 8;
	localparam int SETTLE_CYCLES = 20;

	typedef struct {
		logic                req;
		logic [KEY_BITS-1:0] key;
	} hash_req_t;

	typedef struct {
		logic [SLOT_IDX_W-1:0] slot;
		status_t               stat;
		logic [PROBES_W-1:0]   probes;
	} hash_res_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [PADDR_W-1:0]    paddr = '0;
	logic [PDATA_W-1:0]    pwdata = '0;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  req_type = REQ_INSERT;
	logic [KEY_BITS-1:0]   search_key = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [SLOT_IDX_W-1:0] slot_index;
	logic [STATUS_W-1:0]   status;
	logic [PROBES_W-1:0]   probes_used;

	open_addressing_hash_table uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.search_key  (search_key),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.slot_index  (slot_index),
		.status      (status),
		.probes_used (probes_used)
	);

	// shadow of the table and of probe_mode, kept in step with accepted requests
	logic [KEY_BITS-1:0] slot_copy [TABLE_SIZE];
	logic                mode_copy;

	hash_req_t           pending_reqs [$];     // requests not yet offered
	hash_res_t           awaited_results [$];  // predicted results, oldest first
	logic [KEY_BITS-1:0] key_pool [$];         // every nonzero key sent as an insert

	hash_req_t next_req;
	hash_res_t want;
	logic      in_fire = 1'b0;
	logic      holding = 1'b0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        errors = 0;
	int        cycle_cnt = 0;
	event      hold_go;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// walk the probe sequence over the shadow table; inserts update it
	function automatic hash_res_t probe_table(input logic req, input logic [KEY_BITS-1:0] key);
		hash_res_t   res;
		int unsigned base;
		int unsigned step;
		int unsigned s;
		bit          done;
		res.slot   = '0;
		res.probes = '0;
		done       = 1'b0;
		if (key == '0) begin
			res.stat = ST_ZERO_KEY;
		end else begin
			if (req == REQ_INSERT)
				res.stat = ST_FULL;
			else
				res.stat = ST_NOT_FOUND;
			base = key % TABLE_SIZE;
			for (int unsigned i = 0; i < TABLE_SIZE && !done; i++) begin
				step = (mode_copy == MODE_QUAD) ? (i * i) % TABLE_SIZE : i;
				s = (base + step) % TABLE_SIZE;
				res.probes = PROBES_W'(i + 1);
				if (req == REQ_INSERT ? (slot_copy[s] == '0) : (slot_copy[s] == key)) begin
					if (req == REQ_INSERT)
						slot_copy[s] = key;
					res.slot = SLOT_IDX_W'(s);
					res.stat = ST_OK;
					done     = 1'b1;
				end
			end
		end
		return res;
	endfunction

	// queue a request; keys sent as inserts become candidates for later finds
	task automatic push_req(input logic req, input logic [KEY_BITS-1:0] key);
		hash_req_t r;
		r.req = req;
		r.key = key;
		pending_reqs.push_back(r);
		if (req == REQ_INSERT && key != '0)
			key_pool.push_back(key);
	endtask

	// sender pause: nothing queued, nothing offered, nothing outstanding
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_reqs.size() != 0 || in_valid || awaited_results.size() != 0);
	endtask

	// APB write of probe_mode, then a read back
	task automatic set_probe_mode(input logic mode);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_PROBE_MODE, 2'b00};
		pwdata  <= PDATA_W'(mode);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		mode_copy = mode;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (prdata !== PDATA_W'(mode)) begin
			$display("%0t probe_mode read back: expected %0d, got %0h", $time, mode, prdata);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// one random request; mostly finds, half of all requests on keys sent as inserts
	task automatic push_random_req();
		int unsigned pick;
		logic [KEY_BITS-1:0] k;
		pick = $urandom_range(0, 99);
		k = key_pool[$urandom_range(0, key_pool.size() - 1)];
		if (pick < 5)
			push_req(logic'($urandom_range(0, 1)), '0);
		else if (pick < 17)
			push_req(REQ_INSERT, KEY_BITS'($urandom_range(1, 65535)));
		else if (pick < 67)
			push_req(REQ_FIND, k);
		else if (pick < 80)
			// same home slot as a stored key unless the sum wraps, but a different key
			push_req(REQ_FIND, k + KEY_BITS'(TABLE_SIZE * $urandom_range(1, 20)));
		else
			push_req(REQ_FIND, KEY_BITS'($urandom_range(0, 65535)));
	endtask

	// result check and prediction on the rising edge
	always @(posedge clk) begin
		in_fire <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			awaited_results.push_back(probe_table(req_type, search_key));
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$display("%0t unexpected result: slot %0d status %0d probes %0d",
					$time, slot_index, status, probes_used);
				errors++;
			end else begin
				want = awaited_results.pop_front();
				if (slot_index !== want.slot) begin
					$display("%0t slot_index: expected %0d, got %0d", $time, want.slot, slot_index);
					errors++;
				end
				if (status !== want.stat) begin
					$display("%0t status: expected %0d, got %0d", $time, want.stat, status);
					errors++;
				end
				if (probes_used !== want.probes) begin
					$display("%0t probes_used: expected %0d, got %0d",
						$time, want.probes, probes_used);
					errors++;
				end
			end
		end
	end

	// request driver: a new transaction only once the last one has gone
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_req = pending_reqs.pop_front();
				req_type   <= next_req.req;
				search_key <= next_req.key;
				in_valid   <= 1'b1;
			end else
				in_valid <= 1'b0;
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (arst_n)
			out_stall <= holding || ($urandom_range(0, 99) < recv_stall_pct);
	end

	// long hold-off, counted here so the sender keeps going meanwhile
	always begin
		@(hold_go);
		@(posedge clk);
		holding = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t timed out with %0d results outstanding", $time, awaited_results.size());
			$display("[open_addressing_hash_table] ERROR");
			$finish;
		end
	end

	initial begin
		foreach (slot_copy[j])
			slot_copy[j] = '0;
		mode_copy = MODE_LINEAR;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// linear probing straight out of reset: empty-table miss, zero keys,
		// largest key, duplicate insert
		push_req(REQ_FIND, 16'h0001);
		push_req(REQ_INSERT, 16'h0000);
		push_req(REQ_FIND, 16'h0000);
		push_req(REQ_INSERT, 16'hFFFF);
		push_req(REQ_INSERT, 16'hFFFF);
		push_req(REQ_FIND, 16'hFFFF);
		push_req(REQ_INSERT, 16'd13);
		wait_drained();

		// quadratic: pile keys onto home slot 0 until the sequence runs out,
		// leaving slots it never reaches empty
		set_probe_mode(MODE_QUAD);
		@(posedge clk);
		for (int m = 2; m <= 7; m++)
			push_req(REQ_INSERT, KEY_BITS'(13 * m));
		push_req(REQ_FIND, 16'd91);
		push_req(REQ_FIND, 16'd78);
		wait_drained();

		// back to linear: fill the leftovers, then a genuinely full insert
		set_probe_mode(MODE_LINEAR);
		@(posedge clk);
		push_req(REQ_INSERT, 16'h8000);
		push_req(REQ_INSERT, 16'h0001);
		push_req(REQ_FIND, 16'h0001);
		push_req(REQ_INSERT, 16'h5555);
		push_req(REQ_INSERT, 16'hAAAA);
		push_req(REQ_INSERT, 16'h1234);
		push_req(REQ_INSERT, 16'h00FF);
		push_req(REQ_FIND, 16'hFFFF);
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_probe_mode((p % 2 == 0) ? MODE_QUAD : MODE_LINEAR);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			@(posedge clk);
			if (p == 4)
				-> hold_go;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// mid-phase pause until the block has fully drained
				if (p == 5 && n == PHASE_ITEMS / 2) begin
					wait_drained();
					@(posedge clk);
				end
				push_random_req();
			end
			wait_drained();
		end

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[open_addressing_hash_table] OK");
		else
			$display("[open_addressing_hash_table] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/oaht_pkg.sv
hw/rtl/oaht_ctrl.sv
hw/rtl/oaht_dp.sv
hw/rtl/open_addressing_hash_table.sv
tb/tb_top.sv
